// File: hdl/qmmd_pkg.sv
// Package for the quad X-layout motor mixer with per-axis change filter.
// Holds the register map, field widths, reset values and the input item type.
// No dependencies.
package qmmd_pkg;

  localparam int AXIS_W  = 11;
  localparam int PULSE_W = 11;
  localparam int THR_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int MIX_W   = 15;
  localparam int DIFF_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ELEVATE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_RP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_YAW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX     = 3'd6;

  localparam logic [PULSE_W-1:0] RST_BASE_HIGH = 11'd1450;
  localparam logic [PULSE_W-1:0] RST_BASE_LOW  = 11'd1150;
  localparam logic [THR_W-1:0]   RST_THR_RP    = 10'd20;
  localparam logic [THR_W-1:0]   RST_THR_YAW   = 10'd10;
  localparam logic [PULSE_W-1:0] RST_CLAMP_MIN = 11'd1050;
  localparam logic [PULSE_W-1:0] RST_CLAMP_MAX = 11'd1750;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [PULSE_W-1:0] pulse_t;

  typedef struct packed {
    axis_t roll;
    axis_t pitch;
    axis_t yaw;
    axis_t trim;
    logic  on;
    logic  stop;
  } in_item_t;

endpackage

// File: hdl/quad_motor_mixer_deadband_core.sv
// Top level of the quad X-layout motor mixer with per-axis change filter.
// Input register, filter/mix/clamp logic, held result register.
// Depends on qmmd_pkg.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | roll, pitch, yaw corrections, trim, flags
//  out     | out_valid / out_ready  | four ESC pulse widths
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//
// Input register, then result register; one transaction per cycle while the
// output is not stalled. The filter state updates as an item moves into the
// result register. A stalled output holds both stages; in_ready stays high
// while the input register is empty or moving. Synchronous reset clears the
// valid flags, filter state and held widths and loads config reset values.
module quad_motor_mixer_deadband_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qmmd_pkg::axis_t               roll_correction,
  input  qmmd_pkg::axis_t               pitch_correction,
  input  qmmd_pkg::axis_t               yaw_correction,
  input  qmmd_pkg::axis_t               throttle_trim,
  input  logic                          motors_on,
  input  logic                          stop_request,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qmmd_pkg::pulse_t              esc_front_one,
  output qmmd_pkg::pulse_t              esc_front_two,
  output qmmd_pkg::pulse_t              esc_rear_three,
  output qmmd_pkg::pulse_t              esc_rear_four,
  input  logic                          cfg_wr_en,
  input  logic [qmmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qmmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qmmd_pkg::*;

  logic               elevate_mode;
  pulse_t             base_speed_high;
  pulse_t             base_speed_low;
  logic [THR_W-1:0]   threshold_roll_pitch;
  logic [THR_W-1:0]   threshold_yaw;
  pulse_t             clamp_min;
  pulse_t             clamp_max;

  in_item_t s1;
  logic     s1_valid;
  axis_t    kept_roll;
  axis_t    kept_pitch;
  axis_t    kept_yaw;
  pulse_t   held [4];

  logic     advance;
  axis_t    roll_next;
  axis_t    pitch_next;
  axis_t    yaw_next;
  logic signed [MIX_W-1:0] base_sum;
  logic signed [MIX_W-1:0] mix [4];
  pulse_t   clamped [4];

  function automatic axis_t filter_axis(axis_t fresh, axis_t last, logic [THR_W-1:0] thr);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        mag;
    d   = DIFF_W'(last) - DIFF_W'(fresh);
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return (mag > DIFF_W'(thr)) ? fresh : last;
  endfunction

  function automatic pulse_t clamp_pulse(logic signed [MIX_W-1:0] v, pulse_t lo, pulse_t hi);
    logic signed [MIX_W-1:0] t;
    t = v;
    if (t < $signed({{(MIX_W-PULSE_W){1'b0}}, lo})) t = $signed({{(MIX_W-PULSE_W){1'b0}}, lo});
    if (t > $signed({{(MIX_W-PULSE_W){1'b0}}, hi})) t = $signed({{(MIX_W-PULSE_W){1'b0}}, hi});
    return t[PULSE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      elevate_mode         <= 1'b0;
      base_speed_high      <= RST_BASE_HIGH;
      base_speed_low       <= RST_BASE_LOW;
      threshold_roll_pitch <= RST_THR_RP;
      threshold_yaw        <= RST_THR_YAW;
      clamp_min            <= RST_CLAMP_MIN;
      clamp_max            <= RST_CLAMP_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ELEVATE_MODE: elevate_mode         <= cfg_data[0];
        REG_BASE_HIGH:    base_speed_high      <= cfg_data[PULSE_W-1:0];
        REG_BASE_LOW:     base_speed_low       <= cfg_data[PULSE_W-1:0];
        REG_THR_RP:       threshold_roll_pitch <= cfg_data[THR_W-1:0];
        REG_THR_YAW:      threshold_yaw        <= cfg_data[THR_W-1:0];
        REG_CLAMP_MIN:    clamp_min            <= cfg_data[PULSE_W-1:0];
        REG_CLAMP_MAX:    clamp_max            <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1.roll  <= roll_correction;
      s1.pitch <= pitch_correction;
      s1.yaw   <= yaw_correction;
      s1.trim  <= throttle_trim;
      s1.on    <= motors_on;
      s1.stop  <= stop_request;
    end
  end

  always_comb begin
    roll_next  = filter_axis(s1.roll, kept_roll, threshold_roll_pitch);
    pitch_next = filter_axis(s1.pitch, kept_pitch, threshold_roll_pitch);
    yaw_next   = filter_axis(s1.yaw, kept_yaw, threshold_yaw);
    base_sum   = $signed({{(MIX_W-PULSE_W){1'b0}},
                          (elevate_mode ? base_speed_high : base_speed_low)})
               + MIX_W'(s1.trim);
    mix[0] = base_sum + MIX_W'(roll_next) - MIX_W'(pitch_next) - MIX_W'(yaw_next);
    mix[1] = base_sum - MIX_W'(roll_next) - MIX_W'(pitch_next) + MIX_W'(yaw_next);
    mix[2] = base_sum - MIX_W'(roll_next) + MIX_W'(pitch_next) - MIX_W'(yaw_next);
    mix[3] = base_sum + MIX_W'(roll_next) + MIX_W'(pitch_next) + MIX_W'(yaw_next);
    for (int i = 0; i < 4; i++) begin
      clamped[i] = clamp_pulse(mix[i], clamp_min, clamp_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      kept_roll  <= '0;
      kept_pitch <= '0;
      kept_yaw   <= '0;
      for (int i = 0; i < 4; i++) begin
        held[i] <= '0;
      end
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        kept_roll  <= roll_next;
        kept_pitch <= pitch_next;
        kept_yaw   <= yaw_next;
        if (!s1.on && s1.stop) begin
          for (int i = 0; i < 4; i++) begin
            held[i] <= '0;
          end
        end else if (s1.on && !s1.stop) begin
          for (int i = 0; i < 4; i++) begin
            held[i] <= clamped[i];
          end
        end
      end
    end
  end

  assign esc_front_one  = held[0];
  assign esc_front_two  = held[1];
  assign esc_rear_three = held[2];
  assign esc_rear_four  = held[3];

`ifndef SYNTHESIS
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && !s1.on && s1.stop) |=>
      (esc_front_one == '0 && esc_front_two == '0 &&
       esc_rear_three == '0 && esc_rear_four == '0))
    else $error("stop transaction did not zero outputs");

  a_run_upper: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1.on && !s1.stop) |=>
      (esc_front_one <= $past(clamp_max) && esc_front_two <= $past(clamp_max) &&
       esc_rear_three <= $past(clamp_max) && esc_rear_four <= $past(clamp_max)))
    else $error("running output above clamp_max");

  a_kept_source: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=>
      (kept_roll == $past(s1.roll) || kept_roll == $past(kept_roll)))
    else $error("kept roll from neither fresh nor last value");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid || !advance) |=>
      ($stable(kept_yaw) && $stable(kept_pitch)))
    else $error("filter state moved without a transaction");
`endif

endmodule
